FILE: hdl/atgf_pkg.sv
`default_nettype none

package atgf_pkg;

    localparam int W_TIME = 63;
    localparam int W_OFF  = 64;
    localparam int W_RATE = 20;
    localparam int W_TOL  = 40;
    localparam int W_SMP  = 16;
    localparam int W_IDX  = 2;

    // operand widths of the shared scale unit
    localparam int MUL_W = 30;
    localparam int NUM_W = W_OFF + MUL_W;

    localparam logic [MUL_W-1:0]  NS_PER_SEC = MUL_W'(1000000000);
    localparam logic [MUL_W-1:0]  HALF_SEC   = MUL_W'(500000000);
    localparam logic [W_TIME-1:0] LIM63      = {W_TIME{1'b1}};

    localparam int MAX_FILL_CHUNKS_DEF = 63;

    localparam logic [W_RATE-1:0] RATE_RST = W_RATE'(48000);

    localparam logic [1:0] OP_BUFFER  = 2'd0;
    localparam logic [1:0] OP_SEGMENT = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    localparam logic [W_IDX-1:0] CFG_RATE = 2'd0;
    localparam logic [W_IDX-1:0] CFG_TOL  = 2'd1;
    localparam logic [W_IDX-1:0] CFG_SKIP = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [W_TIME-1:0] time_ns;
        logic              time_valid;
        logic [W_SMP-1:0]  sample_count;
    } t_in_req;

    typedef struct packed {
        logic              is_fill;
        logic [W_TIME-1:0] offset_start;
        logic [W_TIME-1:0] offset_stop;
        logic [W_TIME-1:0] stamp_ns;
        logic [W_TIME-1:0] duration_ns;
        logic [W_SMP-1:0]  trim_front;
        logic              discont;
        logic [W_TIME-1:0] added_total;
        logic [W_TIME-1:0] dropped_total;
        logic              last;
    } t_out_res;

    // floor((a*b + c) / d), saturated
    typedef struct packed {
        logic [W_OFF-1:0] a;
        logic [MUL_W-1:0] b;
        logic [MUL_W-1:0] d;
        logic [MUL_W-1:0] c;
    } t_scl_op;

endpackage

`default_nettype wire

FILE: hdl/atgf_in_if.sv
`default_nettype none

interface atgf_in_if import atgf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/atgf_out_if.sv
`default_nettype none

interface atgf_out_if import atgf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/atgf_scale.sv
`default_nettype none

module atgf_scale import atgf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_scl_op           i_op,
    output logic                   o_done,
    output logic [W_TIME-1:0]      o_quo
);

    localparam int CW = $clog2(NUM_W);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state             r_state;
    logic [NUM_W-1:0]   r_mcand;
    logic [MUL_W-1:0]   r_mplier;
    logic [NUM_W-1:0]   r_acc;
    logic [MUL_W-1:0]   r_rem;
    logic [MUL_W-1:0]   r_div;
    logic [CW-1:0]      r_cnt;
    logic               r_done;
    logic [W_TIME-1:0]  r_quo;

    logic [MUL_W:0]     w_trial;
    logic               w_ge;

    assign w_trial = {r_rem, r_acc[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_mcand  <= {{MUL_W{1'b0}}, i_op.a};
                    r_mplier <= i_op.b;
                    r_acc    <= {{W_OFF{1'b0}}, i_op.c};
                    r_div    <= i_op.d;
                    r_cnt    <= '0;
                    r_state  <= S_MUL;
                end
            end
            S_MUL: begin
                // shift-add, one multiplier bit a cycle
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[NUM_W-2:0], 1'b0};
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CW'(MUL_W - 1)) begin
                    r_cnt   <= '0;
                    r_rem   <= '0;
                    r_state <= S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, quotient bits shift into the numerator
                if (w_ge) begin
                    r_rem <= MUL_W'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[MUL_W-1:0];
                end
                r_acc <= {r_acc[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_state <= S_FIN;
                end
            end
            S_FIN: begin
                r_quo   <= (|r_acc[NUM_W-1:W_TIME]) ? LIM63 : r_acc[W_TIME-1:0];
                r_done  <= 1'b1;
                r_state <= S_IDLE;
            end
            default: r_state <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: hdl/audio_timestamp_gap_filler.sv
// Audio timestamp gap filler.
// i_in carries buffer descriptors (opcode, timestamp, sample count) under a
// valid/ready handshake; o_out carries result requests, one passed buffer and
// up to MAX_FILL_CHUNKS silence fills per input request, the final one marked
// by last. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): 0 sample rate, 1 tolerance in ns, 2 skip-to-first.
// Every time/offset conversion runs on one shared scale unit: a shift-add
// multiply and a restoring divide. A buffer costs one conversion for its
// input offset, one per emitted result, plus two on a resync (three with
// skip-to-first). Segment and flush requests are handled in the idle state
// and give no result.
// The input is not ready while a buffer is processed. A finished result sits
// in an output register, so the next request is taken while it waits; when
// the receiver stalls, the sequencer holds at the next result until the
// register frees up. Reset (synchronous, active low) restores the register
// defaults and clears offsets, counts and time, and arms resync and discont.
`default_nettype none

module audio_timestamp_gap_filler import atgf_pkg::*; #(
    parameter int MAX_FILL_CHUNKS = MAX_FILL_CHUNKS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [W_IDX-1:0] i_cfg_idx,
    input  wire logic [W_TOL-1:0] i_cfg_data,
    atgf_in_if.sink               i_in,
    atgf_out_if.source            o_out
);

    localparam int FW = $clog2(MAX_FILL_CHUNKS + 1);
    localparam logic [FW-1:0] LAST_FILL = FW'(MAX_FILL_CHUNKS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RS_OFF, ST_RS_TIME, ST_RS_SKIP, ST_IN_OFF, ST_DECIDE,
        ST_FILL, ST_FILL_T, ST_PASS_GO, ST_PASS_T, ST_EMIT
    } t_state;

    // configuration
    logic [W_RATE-1:0] r_rate;
    logic [W_TOL-1:0]  r_tol;
    logic              r_skip;

    // stream state
    logic [W_OFF-1:0]  r_exp_off;
    logic [W_TIME-1:0] r_exp_time;
    logic              r_resync;
    logic              r_discont;
    logic [W_TIME-1:0] r_seg;
    logic [W_TIME-1:0] r_added;
    logic [W_TIME-1:0] r_dropped;

    // current buffer
    t_state            r_state;
    t_state            r_ret;
    logic [W_TIME-1:0] r_t;
    logic              r_tv;
    logic [W_SMP-1:0]  r_smp;
    logic [W_TIME-1:0] r_in_off;
    logic [W_OFF-1:0]  r_in_end;
    logic [W_OFF-1:0]  r_remain;
    logic [W_SMP-1:0]  r_trim;
    logic              r_left_nz;
    logic [FW-1:0]     r_nfill;
    logic [W_OFF-1:0]  r_fstart;
    logic [W_TIME-1:0] r_prev;

    // scale unit handoff and output register
    logic              r_scl_start;
    t_scl_op           r_scl_op;
    logic              w_scl_done;
    logic [W_TIME-1:0] w_scl_q;
    t_out_res          r_res;
    t_out_res          r_out;
    logic              r_out_valid;

    logic [MUL_W-1:0]  w_rate;
    logic [W_OFF-1:0]  w_rate64;
    logic [W_TIME-1:0] w_in_time;
    logic [W_TIME-1:0] w_diff;
    logic              w_within;
    logic [W_OFF-1:0]  w_off64;
    logic [W_OFF-1:0]  w_raw_end;
    logic [W_OFF-1:0]  w_tol_end;
    logic [W_OFF-1:0]  w_cur;
    logic [W_OFF-1:0]  w_fill_end;
    logic              w_fill_done;
    logic [W_SMP-1:0]  w_trim;

    atgf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_scl_start),
        .i_op    (r_scl_op),
        .o_done  (w_scl_done),
        .o_quo   (w_scl_q)
    );

    function automatic t_scl_op mk_op(input logic [W_OFF-1:0] a, input logic [MUL_W-1:0] b,
                                      input logic [MUL_W-1:0] d, input logic [MUL_W-1:0] c);
        t_scl_op op;
        op.a = a;
        op.b = b;
        op.d = d;
        op.c = c;
        return op;
    endfunction

    // a zero rate counts as one
    assign w_rate   = (r_rate == '0) ? MUL_W'(1) : {{(MUL_W-W_RATE){1'b0}}, r_rate};
    assign w_rate64 = {{(W_OFF-MUL_W){1'b0}}, w_rate};

    assign w_in_time = r_tv ? r_t : r_exp_time;
    assign w_diff    = (w_in_time >= r_exp_time) ? (w_in_time - r_exp_time)
                                                 : (r_exp_time - w_in_time);
    assign w_within  = w_diff <= {{(W_TIME-W_TOL){1'b0}}, r_tol};
    assign w_off64   = {1'b0, r_in_off};
    assign w_raw_end = w_off64 + {{(W_OFF-W_SMP){1'b0}}, r_smp};
    assign w_tol_end = r_exp_off + {{(W_OFF-W_SMP){1'b0}}, r_smp};
    assign w_trim    = W_SMP'(r_exp_off - w_off64);

    // chunks are capped at one second, except the final allowed one
    assign w_cur       = (r_nfill != LAST_FILL && r_remain > w_rate64) ? w_rate64 : r_remain;
    assign w_fill_end  = r_exp_off + w_cur;
    assign w_fill_done = (r_remain == '0) || (r_nfill == LAST_FILL);

    always_ff @(posedge i_clk) begin
        r_scl_start <= 1'b0;
        if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RATE: r_rate <= i_cfg_data[W_RATE-1:0];
                CFG_TOL:  r_tol  <= i_cfg_data;
                CFG_SKIP: r_skip <= i_cfg_data[0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    r_t   <= i_in.data.time_ns;
                    r_tv  <= i_in.data.time_valid;
                    r_smp <= i_in.data.sample_count;
                    unique case (i_in.data.opcode)
                        OP_FLUSH: begin
                            r_resync  <= 1'b1;
                            r_discont <= 1'b1;
                            r_seg     <= '0;
                        end
                        OP_SEGMENT: begin
                            r_seg    <= i_in.data.time_ns;
                            r_resync <= 1'b1;
                        end
                        OP_BUFFER: begin
                            r_scl_start <= 1'b1;
                            if (r_resync) begin
                                // resync: restart at the segment start
                                r_resync  <= 1'b0;
                                r_discont <= 1'b1;
                                r_scl_op  <= mk_op({1'b0, r_seg}, w_rate, NS_PER_SEC, '0);
                                r_state   <= ST_RS_OFF;
                            end else begin
                                r_scl_op <= mk_op({1'b0, i_in.data.time_valid ?
                                                  i_in.data.time_ns : r_exp_time},
                                                  w_rate, NS_PER_SEC, HALF_SEC);
                                r_state  <= ST_IN_OFF;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RS_OFF: begin
                if (w_scl_done) begin
                    r_exp_off   <= {1'b0, w_scl_q};
                    r_scl_op    <= mk_op({1'b0, w_scl_q}, NS_PER_SEC, w_rate, '0);
                    r_scl_start <= 1'b1;
                    r_state     <= ST_RS_TIME;
                end
            end
            ST_RS_TIME: begin
                if (w_scl_done) begin
                    r_exp_time  <= w_scl_q;
                    r_scl_start <= 1'b1;
                    if (r_skip && r_tv) begin
                        r_scl_op <= mk_op({1'b0, r_t}, w_rate, NS_PER_SEC, '0);
                        r_state  <= ST_RS_SKIP;
                    end else begin
                        r_scl_op <= mk_op({1'b0, r_tv ? r_t : w_scl_q},
                                          w_rate, NS_PER_SEC, HALF_SEC);
                        r_state  <= ST_IN_OFF;
                    end
                end
            end
            ST_RS_SKIP: begin
                if (w_scl_done) begin
                    r_exp_off   <= {1'b0, w_scl_q};
                    r_exp_time  <= r_t;
                    r_scl_op    <= mk_op({1'b0, r_t}, w_rate, NS_PER_SEC, HALF_SEC);
                    r_scl_start <= 1'b1;
                    r_state     <= ST_IN_OFF;
                end
            end
            ST_IN_OFF: begin
                if (w_scl_done) begin
                    r_in_off <= w_scl_q;
                    r_state  <= ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                r_trim    <= '0;
                r_nfill   <= '0;
                r_in_end  <= w_raw_end;
                r_left_nz <= r_smp != '0;
                priority if (w_within) begin
                    // close enough: snap onto the expected offset
                    r_in_end <= w_tol_end;
                    r_state  <= (r_smp != '0) ? ST_PASS_GO : ST_IDLE;
                end else if (w_off64 > r_exp_off) begin
                    r_remain <= w_off64 - r_exp_off;
                    r_state  <= ST_FILL;
                end else if (w_off64 < r_exp_off) begin
                    if (w_raw_end <= r_exp_off) begin
                        // drop the whole buffer
                        r_dropped <= r_dropped + {{(W_TIME-W_SMP){1'b0}}, r_smp};
                        r_left_nz <= 1'b0;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_trim    <= w_trim;
                        r_dropped <= r_dropped + {{(W_TIME-W_SMP){1'b0}}, w_trim};
                        r_left_nz <= 1'b1;
                        r_state   <= ST_PASS_GO;
                    end
                end else begin
                    r_state <= (r_smp != '0) ? ST_PASS_GO : ST_IDLE;
                end
            end
            ST_FILL: begin
                r_fstart    <= r_exp_off;
                r_remain    <= r_remain - w_cur;
                r_exp_off   <= w_fill_end;
                r_prev      <= r_exp_time;
                r_added     <= r_added + w_cur[W_TIME-1:0];
                r_scl_op    <= mk_op(w_fill_end, NS_PER_SEC, w_rate, '0);
                r_scl_start <= 1'b1;
                r_state     <= ST_FILL_T;
            end
            ST_FILL_T: begin
                if (w_scl_done) begin
                    r_exp_time          <= w_scl_q;
                    r_res.is_fill       <= 1'b1;
                    r_res.offset_start  <= r_fstart[W_TIME-1:0];
                    r_res.offset_stop   <= r_exp_off[W_TIME-1:0];
                    r_res.stamp_ns      <= r_prev;
                    r_res.duration_ns   <= w_scl_q - r_prev;
                    r_res.trim_front    <= '0;
                    r_res.discont       <= r_discont;
                    r_res.added_total   <= r_added;
                    r_res.dropped_total <= r_dropped;
                    r_res.last          <= w_fill_done && !r_left_nz;
                    r_discont           <= 1'b0;
                    r_nfill             <= r_nfill + 1'b1;
                    r_ret               <= w_fill_done ? (r_left_nz ? ST_PASS_GO : ST_IDLE)
                                                       : ST_FILL;
                    r_state             <= ST_EMIT;
                end
            end
            ST_PASS_GO: begin
                r_prev      <= r_exp_time;
                r_scl_op    <= mk_op(r_in_end, NS_PER_SEC, w_rate, '0);
                r_scl_start <= 1'b1;
                r_state     <= ST_PASS_T;
            end
            ST_PASS_T: begin
                if (w_scl_done) begin
                    r_exp_time          <= w_scl_q;
                    r_res.is_fill       <= 1'b0;
                    r_res.offset_start  <= r_exp_off[W_TIME-1:0];
                    r_res.offset_stop   <= r_in_end[W_TIME-1:0];
                    r_res.stamp_ns      <= r_prev;
                    r_res.duration_ns   <= w_scl_q - r_prev;
                    r_res.trim_front    <= r_trim;
                    r_res.discont       <= r_discont;
                    r_res.added_total   <= r_added;
                    r_res.dropped_total <= r_dropped;
                    r_res.last          <= 1'b1;
                    r_discont           <= 1'b0;
                    r_exp_off           <= r_in_end;
                    r_ret               <= ST_IDLE;
                    r_state             <= ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    r_out       <= r_res;
                    r_out_valid <= 1'b1;
                    r_state     <= r_ret;
                end
            end
            default: r_state <= ST_IDLE;
        endcase

        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scl_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_rate      <= RATE_RST;
            r_tol       <= '0;
            r_skip      <= 1'b0;
            r_exp_off   <= '0;
            r_exp_time  <= '0;
            r_resync    <= 1'b1;
            r_discont   <= 1'b1;
            r_seg       <= '0;
            r_added     <= '0;
            r_dropped   <= '0;
        end
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

FILE: tb/atgf_checker.sv
`default_nettype none

module atgf_checker import atgf_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [W_IDX-1:0] i_cfg_idx,
    input  wire logic [W_TOL-1:0] i_cfg_data,
    atgf_in_if                    in_ch,
    atgf_out_if                   out_ch,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_fills,
    output int                    o_passed
);

    localparam logic [63:0] NSEC = 64'd1000000000;

    // register copies
    logic [W_RATE-1:0] rate_reg;
    logic [W_TOL-1:0]  tol_reg;
    logic              skip_reg;

    // stream position
    logic [63:0] next_off;
    logic [63:0] next_time;
    logic [63:0] seg_start;
    logic [63:0] added_sum;
    logic [63:0] dropped_sum;
    logic        resync_armed;
    logic        discont_armed;

    t_out_res expected_q[$];

    // floor((a*b + c) / d), saturated at 63 bits
    function automatic logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d, logic [63:0] c);
        logic [127:0] acc;
        acc = {64'd0, a} * {64'd0, b} + {64'd0, c};
        acc = acc / {64'd0, d};
        if (acc > {65'd0, LIM63})
            return {1'b0, LIM63};
        return acc[63:0];
    endfunction

    task automatic push_result(logic fill, logic [63:0] ostart, logic [63:0] ostop,
                               logic [63:0] stamp, logic [63:0] dur,
                               logic [63:0] trim);
        t_out_res r;
        r.is_fill       = fill;
        r.offset_start  = ostart[W_TIME-1:0];
        r.offset_stop   = ostop[W_TIME-1:0];
        r.stamp_ns      = stamp[W_TIME-1:0];
        r.duration_ns   = dur[W_TIME-1:0];
        r.trim_front    = trim[W_SMP-1:0];
        r.discont       = discont_armed;
        r.added_total   = added_sum[W_TIME-1:0];
        r.dropped_total = dropped_sum[W_TIME-1:0];
        r.last          = 1'b0;
        discont_armed   = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic predict_request(t_in_req req);
        logic [63:0] rate, in_time, in_off, in_end, left, trim, prev;
        logic [63:0] remain, cur, start, smp;
        int n;
        n = 0;
        trim = '0;
        smp = 64'(req.sample_count);
        if (req.opcode == OP_FLUSH) begin
            resync_armed  = 1'b1;
            discont_armed = 1'b1;
            seg_start     = '0;
            return;
        end
        if (req.opcode == OP_SEGMENT) begin
            seg_start    = 64'(req.time_ns);
            resync_armed = 1'b1;
            return;
        end
        if (req.opcode != OP_BUFFER)
            return;

        rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
        if (resync_armed) begin
            resync_armed  = 1'b0;
            discont_armed = 1'b1;
            next_off  = scale_sat(seg_start, rate, NSEC, 64'd0);
            next_time = scale_sat(next_off, NSEC, rate, 64'd0);
            if (skip_reg && req.time_valid) begin
                next_off  = scale_sat(64'(req.time_ns), rate, NSEC, 64'd0);
                next_time = 64'(req.time_ns);
            end
        end

        in_time = req.time_valid ? 64'(req.time_ns) : next_time;
        in_off  = scale_sat(in_time, rate, NSEC, NSEC / 2);
        in_end  = in_off + smp;
        left    = smp;

        if ((in_time >= next_time && in_time - next_time <= 64'(tol_reg)) ||
            (in_time < next_time && next_time - in_time <= 64'(tol_reg))) begin
            // close enough: snap onto the expected position
            in_end = next_off + smp;
        end else if (in_off > next_off) begin
            // late buffer: pad with silence in chunks of up to one second, the last allowed chunk uncapped
            remain = in_off - next_off;
            while (remain > 0 && n < MAX_FILL_CHUNKS_DEF) begin
                cur   = remain;
                start = next_off;
                if (n != MAX_FILL_CHUNKS_DEF - 1 && cur > rate)
                    cur = rate;
                remain    = remain - cur;
                next_off  = next_off + cur;
                prev      = next_time;
                next_time = scale_sat(next_off, NSEC, rate, 64'd0);
                added_sum = added_sum + cur;
                push_result(1'b1, start, next_off, prev, next_time - prev, 64'd0);
                n++;
            end
        end else if (in_off < next_off) begin
            // early buffer: cut the overlap or drop it whole
            if (in_end <= next_off) begin
                dropped_sum = dropped_sum + smp;
                left = '0;
            end else begin
                trim = next_off - in_off;
                dropped_sum = dropped_sum + trim;
                left = smp - trim;
            end
        end

        if (left > 0) begin
            prev      = next_time;
            next_time = scale_sat(in_end, NSEC, rate, 64'd0);
            push_result(1'b0, next_off, in_end, prev, next_time - prev, trim);
            next_off = in_end;
            n++;
        end
        if (n > 0)
            expected_q[expected_q.size() - 1].last = 1'b1;
    endtask

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
        o_fail_count++;
    endtask

    task automatic compare_result(t_out_res got);
        t_out_res want;
        if (expected_q.size() == 0) begin
            report("unexpected result, offset_start", 64'(got.offset_start), 64'd0);
            return;
        end
        want = expected_q.pop_front();
        if (want.is_fill) o_fills++; else o_passed++;
        if (got.is_fill != want.is_fill)
            report("is_fill", 64'(got.is_fill), 64'(want.is_fill));
        if (got.offset_start != want.offset_start)
            report("offset_start", 64'(got.offset_start), 64'(want.offset_start));
        if (got.offset_stop != want.offset_stop)
            report("offset_stop", 64'(got.offset_stop), 64'(want.offset_stop));
        if (got.stamp_ns != want.stamp_ns)
            report("stamp_ns", 64'(got.stamp_ns), 64'(want.stamp_ns));
        if (got.duration_ns != want.duration_ns)
            report("duration_ns", 64'(got.duration_ns), 64'(want.duration_ns));
        if (got.trim_front != want.trim_front)
            report("trim_front", 64'(got.trim_front), 64'(want.trim_front));
        if (got.discont != want.discont)
            report("discont", 64'(got.discont), 64'(want.discont));
        if (got.added_total != want.added_total)
            report("added_total", 64'(got.added_total), 64'(want.added_total));
        if (got.dropped_total != want.dropped_total)
            report("dropped_total", 64'(got.dropped_total), 64'(want.dropped_total));
        if (got.last != want.last)
            report("last", 64'(got.last), 64'(want.last));
    endtask

    initial begin
        o_fail_count = 0;
        o_fills      = 0;
        o_passed     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_reg      = RATE_RST;
            tol_reg       = '0;
            skip_reg      = 1'b0;
            next_off      = '0;
            next_time     = '0;
            seg_start     = '0;
            added_sum     = '0;
            dropped_sum   = '0;
            resync_armed  = 1'b1;
            discont_armed = 1'b1;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RATE: rate_reg = i_cfg_data[W_RATE-1:0];
                    CFG_TOL:  tol_reg  = i_cfg_data;
                    CFG_SKIP: skip_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_request(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                compare_result(out_ch.data);
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
    import atgf_pkg::*;

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // cycles with no handshake at all before the run is declared hung
    localparam int STALL_LIMIT = 60000;
    // drain time for a request that ends without any result
    localparam int SETTLE_CYCLES = 1500;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam longint NSEC = 1000000000;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [W_IDX-1:0] cfg_idx;
    logic [W_TOL-1:0] cfg_data;

    atgf_in_if  in_ch ();
    atgf_out_if out_ch ();

    int fail_count, pending, fills, passed;
    int sent, settings, stall_cycles;
    bit long_hold;   // ask the receiver for one long stall
    bit no_idle;     // run a stretch with neither side idling
    longint unsigned cur_rate;
    longint unsigned now_ns;   // where the source thinks its stream is

    audio_timestamp_gap_filler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    atgf_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_fills      (fills),
        .o_passed     (passed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog: restart the count on any handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall a random number of cycles before each result, or hold
    // off for a long stretch when asked.
    initial begin
        int wait_n;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            wait_n = no_idle ? 0 : $urandom_range(0, 19);
            if (wait_n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready) && !long_hold);
        end
    end

    // Offer one request; valid stays high afterwards so a back-to-back
    // request follows without valid dropping in between.
    task automatic send(logic [1:0] op, logic [W_TIME-1:0] t, logic tv,
                        logic [W_SMP-1:0] n, bit hurry = 0);
        int gap;
        gap = (no_idle || hurry) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.data.opcode       <= op;
        in_ch.data.time_ns      <= t;
        in_ch.data.time_valid   <= tv;
        in_ch.data.sample_count <= n;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    // Drop valid and wait until the block has drained.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [W_IDX-1:0] idx, logic [W_TOL-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [W_RATE-1:0] rate, logic [W_TOL-1:0] tol, bit skip);
        settle();
        write_reg(CFG_RATE, W_TOL'(rate));
        write_reg(CFG_TOL, tol);
        write_reg(CFG_SKIP, W_TOL'(skip));
        cur_rate = (rate == '0) ? 64'd1 : 64'(rate);
        settings++;
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // Mostly a well-behaved stream with jitter, gaps, overlaps and segment
    // changes; the rest is noise across the whole field ranges.
    task automatic random_stream(int count);
        int pick;
        logic [W_SMP-1:0] n;
        logic [62:0] t;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            n = ($urandom_range(0, 9) == 0) ? W_SMP'($urandom())
                                            : W_SMP'($urandom_range(1, 2048));
            if (pick < 60) begin
                t = 63'(now_ns + $urandom_range(0, 3000) - 1500);
                send(OP_BUFFER, t, 1'b1, n);
                now_ns = 64'(t) + n * NSEC / cur_rate;
            end else if (pick < 70) begin
                // late: silence gets inserted
                t = 63'(now_ns + longint'($urandom_range(1, 3000)) * 1000000);
                send(OP_BUFFER, t, 1'b1, n);
                now_ns = 64'(t) + n * NSEC / cur_rate;
            end else if (pick < 80) begin
                // early: overlap gets trimmed or the buffer dropped
                t = 63'(now_ns - (n * NSEC / cur_rate) * $urandom_range(1, 150) / 100);
                send(OP_BUFFER, t, 1'b1, n);
            end else if (pick < 85) begin
                send(OP_BUFFER, rand63(), 1'b0, n);
                now_ns = now_ns + n * NSEC / cur_rate;
            end else if (pick < 89) begin
                send(OP_SEGMENT, 63'(now_ns), 1'($urandom_range(0, 1)), n);
            end else if (pick < 92) begin
                send(OP_FLUSH, rand63(), 1'($urandom_range(0, 1)), n);
            end else if (pick < 94) begin
                // end of stream: zero samples up to a later time
                t = 63'(now_ns + $urandom_range(0, 2000000000));
                send(OP_BUFFER, t, 1'b1, '0);
                now_ns = 64'(t);
            end else begin
                t = ($urandom_range(0, 3) == 0) ? rand63() : 63'(now_ns + $urandom());
                send(2'($urandom_range(0, 3)), t, 1'($urandom_range(0, 1)),
                     W_SMP'($urandom()));
                if (t < 63'(now_ns) + 63'd100000000000) now_ns = 64'(t);
            end
        end
    endtask

    initial begin
        sent = 0;
        settings = 0;
        long_hold = 1'b0;
        no_idle = 1'b0;
        cur_rate = 48000;
        now_ns = 0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset settings.
        send(OP_BUFFER, '0, 1'b0, 16'd480);
        send(OP_BUFFER, 63'd10000000, 1'b1, 16'd480);
        send(OP_BUFFER, 63'd2520000000, 1'b1, 16'd100);
        send(OP_BUFFER, 63'd2500000000, 1'b1, 16'd2000);
        send(OP_BUFFER, 63'd100, 1'b1, 16'd50);
        send(OP_BUFFER, 63'd4000000000, 1'b1, '0);
        send(OP_BUFFER, '0, 1'b0, 16'hFFFF);
        send(OP_UNUSED, {63{1'b1}}, 1'b1, 16'hFFFF);
        send(OP_SEGMENT, 63'd7000000000, 1'b0, '0);
        send(OP_BUFFER, 63'd7000500000, 1'b1, 16'd1);
        send(OP_FLUSH, '0, 1'b0, '0);
        send(OP_BUFFER, 63'd90000000000, 1'b1, 16'd10);
        send(OP_BUFFER, {63{1'b1}}, 1'b1, 16'hFFFF);
        send(OP_FLUSH, {63{1'b1}}, 1'b1, 16'hFFFF);
        send(OP_BUFFER, 63'd1, 1'b1, '0);

        // Register extremes: zero rate, widest tolerance, skip to first.
        apply_setting('0, '0, 1'b1);
        send(OP_FLUSH, '0, 1'b0, '0);
        send(OP_BUFFER, 63'd5000000000, 1'b1, 16'd3);
        send(OP_BUFFER, 63'd9000000000, 1'b1, 16'd2);
        apply_setting({W_RATE{1'b1}}, {W_TOL{1'b1}}, 1'b0);
        send(OP_BUFFER, 63'd123456789, 1'b1, 16'd777);
        send(OP_BUFFER, 63'd999999999999, 1'b1, 16'd1);
        apply_setting(20'd768000, 40'd20833, 1'b1);
        send(OP_FLUSH, '0, 1'b0, '0);
        send(OP_BUFFER, 63'd3000000000, 1'b1, 16'd768);
        send(OP_BUFFER, 63'd3000010000, 1'b1, 16'd768);

        // Random part over several settings.
        apply_setting(20'd48000, 40'd20000, 1'b0);
        now_ns = 0;
        random_stream(80);

        // Fill the block while the receiver holds off.
        long_hold = 1'b1;
        repeat (12) send(OP_BUFFER, '0, 1'b0, 16'd64, 1'b1);
        settle();
        random_stream(40);

        // Source pauses until every expected result is in.
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        no_idle = 1'b1;
        random_stream(40);
        no_idle = 1'b0;

        apply_setting(20'd44100, 40'd0, 1'b1);
        send(OP_FLUSH, '0, 1'b0, '0);
        now_ns = 64'd1000000000;
        random_stream(70);

        apply_setting(20'd1, 40'd5000000000, 1'b0);
        now_ns = 0;
        random_stream(30);

        apply_setting(20'd768000, {W_TOL{1'b1}}, 1'b1);
        random_stream(40);

        apply_setting(20'($urandom_range(1, 1048575)), 40'($urandom_range(0, 100000)),
                      1'($urandom_range(0, 1)));
        random_stream(50);

        settle();
        $display("Sent %0d requests over %0d register settings", sent, settings);
        $display("Checked %0d passed buffers and %0d silence fills", passed, fills);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/atgf_pkg.sv
hdl/atgf_in_if.sv
hdl/atgf_out_if.sv
hdl/atgf_scale.sv
hdl/audio_timestamp_gap_filler.sv
tb/atgf_checker.sv
tb/tb.sv
